/* sv/rtfb_pkg.sv */
package rtfb_pkg;

	// framing bytes
	localparam logic [7:0] DELIM_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] XON_BYTE   = 8'h11;
	localparam logic [7:0] XOFF_BYTE  = 8'h13;
	localparam logic [7:0] ESC_FLIP   = 8'h20;

	// fixed header and field bytes
	localparam logic [7:0] LEN_HI     = 8'h00;
	localparam logic [7:0] LEN_LO     = 8'h1C;
	localparam logic [7:0] FRAME_TYPE = 8'h10;
	localparam logic [7:0] FRAME_ID   = 8'h01;
	localparam logic [7:0] OPT_HI     = 8'hFF;
	localparam logic [7:0] OPT_LO     = 8'hFE;
	localparam logic [7:0] ZERO_BYTE  = 8'h00;

	localparam logic [63:0] DEST_RESET = 64'h0000_0000_0000_FFFF;

	// byte positions within the unescaped frame
	localparam int IDX_W = 5;
	localparam logic [IDX_W-1:0] IDX_SUM_FIRST = 5'd3;
	localparam logic [IDX_W-1:0] IDX_DEST      = 5'd5;
	localparam logic [IDX_W-1:0] IDX_PAYLOAD   = 5'd23;
	localparam logic [IDX_W-1:0] IDX_LAST      = 5'd31;

	typedef struct packed {
		logic [15:0] record_id;
		logic [23:0] timestamp;
		logic [7:0]  data_length;
		logic [63:0] payload;
	} in_word_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       frame_end;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic emit_plain;
		logic emit_esc;
		logic emit_flip;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic esc;
		logic last;
		logic slot_free;
	} status_t;

endpackage

/* sv/rtfb_ctrl.sv */
module rtfb_ctrl
	import rtfb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EMIT = 3'b010,
		ST_FLIP = 3'b100
	} state_t;

	state_t state_q, state_d;

	// accept a record only between frames
	assign in_stall = (state_q != ST_IDLE);

	// sequence header, escape prefix and flipped byte
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.slot_free) begin
					if (status.esc) begin
						cmd.emit_esc = 1'b1;
						state_d      = ST_FLIP;
					end else begin
						cmd.emit_plain = 1'b1;
						if (status.last) state_d = ST_IDLE;
					end
				end
			end
			ST_FLIP: begin
				if (status.slot_free) begin
					cmd.emit_flip = 1'b1;
					state_d       = status.last ? ST_IDLE : ST_EMIT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

/* sv/rtfb_dp.sv */
module rtfb_dp
	import rtfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  in_word_t   in_data,
	input  logic       cfg_wr_en,
	input  logic [63:0] cfg_wr_data,
	input  cmd_t       cmd,
	output status_t    status,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_data
);

	in_word_t         rec_q;
	logic [63:0]      dest_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic             out_valid_q;
	out_word_t        out_data_q;

	logic [7:0]       cur_byte;
	logic [2:0]       dest_off;
	logic [2:0]       pay_off;
	logic             advance;
	logic             emit;

	assign dest_off = 3'(idx_q - IDX_DEST);
	assign pay_off  = 3'(idx_q - IDX_PAYLOAD);

	// select the unescaped frame byte at the current position
	always_comb begin
		unique case (idx_q) inside
			5'd0:         cur_byte = DELIM_BYTE;
			5'd1:         cur_byte = LEN_HI;
			5'd2:         cur_byte = LEN_LO;
			5'd3:         cur_byte = FRAME_TYPE;
			5'd4:         cur_byte = FRAME_ID;
			[5'd5:5'd12]: cur_byte = dest_q[(7 - dest_off) * 8 +: 8];
			5'd13:        cur_byte = OPT_HI;
			5'd14:        cur_byte = OPT_LO;
			5'd15, 5'd16: cur_byte = ZERO_BYTE;
			5'd17:        cur_byte = rec_q.timestamp[23:16];
			5'd18:        cur_byte = rec_q.timestamp[15:8];
			5'd19:        cur_byte = rec_q.timestamp[7:0];
			5'd20:        cur_byte = rec_q.record_id[15:8];
			5'd21:        cur_byte = rec_q.record_id[7:0];
			5'd22:        cur_byte = rec_q.data_length;
			[5'd23:5'd30]: cur_byte = rec_q.payload[(7 - pay_off) * 8 +: 8];
			default:      cur_byte = ~sum_q;
		endcase
	end

	// report escape need (never on the delimiter) and frame end
	assign status.esc = (idx_q != '0) &&
		(cur_byte == DELIM_BYTE || cur_byte == ESC_BYTE ||
		 cur_byte == XON_BYTE   || cur_byte == XOFF_BYTE);
	assign status.last      = (idx_q == IDX_LAST);
	assign status.slot_free = !out_valid_q || !out_stall;

	assign advance = cmd.emit_plain || cmd.emit_flip;
	assign emit    = advance || cmd.emit_esc;

	// hold the destination register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        dest_q <= DEST_RESET;
		else if (cfg_wr_en) dest_q <= cfg_wr_data;
	end

	// capture the record
	always_ff @(posedge clk) begin
		if (cmd.load) rec_q <= in_data;
	end

	// advance position and accumulate checksum over bytes 3..30
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
			sum_q <= '0;
		end else if (advance) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q >= IDX_SUM_FIRST && idx_q != IDX_LAST) sum_q <= sum_q + cur_byte;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         out_valid_q <= 1'b0;
		else if (emit)       out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_esc) begin
			out_data_q.tx_byte   <= ESC_BYTE;
			out_data_q.frame_end <= 1'b0;
		end else if (cmd.emit_flip) begin
			out_data_q.tx_byte   <= cur_byte ^ ESC_FLIP;
			out_data_q.frame_end <= status.last;
		end else if (cmd.emit_plain) begin
			out_data_q.tx_byte   <= cur_byte;
			out_data_q.frame_end <= status.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* sv/radio_tx_frame_builder_escaped.sv */
// channel   direction  payload      handshake
// in        input      in_word_t    in_valid / in_stall
// out       output     out_word_t   out_valid / out_stall
// cfg       input      64-bit dest  cfg_wr_en / cfg_wr_data
//
// A record is loaded, then the byte sequencer issues one wire word per cycle while the
// output is not stalled; a frame is 32 to 63 words.
// in_stall is high from the accept until the last word of the frame is issued.
// out_stall holds the output register and, while it holds a word, freezes the sequencer.
// Reset clears control state and sets the destination to broadcast.
module radio_tx_frame_builder_escaped
	import rtfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data
);

	cmd_t    cmd;
	status_t status;

	rtfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rtfb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

/* tb/frame_word_checker.sv */
module frame_word_checker
	import rtfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_word_t   out_data,
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data,
	output int          fail_count,
	output int          words_due_count
);

	logic [63:0] dest_copy;
	out_word_t   words_due[$];

	// print one line per mismatch, quiet down after the first few dozen
	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (fail_count < 50) begin
			$display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
		end
		fail_count++;
	endtask

	// build the frame for one record and queue its escaped wire words
	task automatic queue_frame_words(input in_word_t rec);
		logic [7:0] frame [32];
		logic [7:0] sum;
		out_word_t  w;
		frame[0] = DELIM_BYTE;
		frame[1] = LEN_HI;
		frame[2] = LEN_LO;
		frame[3] = FRAME_TYPE;
		frame[4] = FRAME_ID;
		for (int i = 0; i < 8; i++) begin
			frame[5 + i]  = dest_copy[63 - 8 * i -: 8];
			frame[23 + i] = rec.payload[63 - 8 * i -: 8];
		end
		frame[13] = OPT_HI;
		frame[14] = OPT_LO;
		frame[15] = ZERO_BYTE;
		frame[16] = ZERO_BYTE;
		frame[17] = rec.timestamp[23:16];
		frame[18] = rec.timestamp[15:8];
		frame[19] = rec.timestamp[7:0];
		frame[20] = rec.record_id[15:8];
		frame[21] = rec.record_id[7:0];
		frame[22] = rec.data_length;

		// checksum covers everything after the length field
		sum = 8'h00;
		for (int i = 3; i < 31; i++) begin
			sum = sum + frame[i];
		end
		frame[31] = 8'hFF - sum;

		// the start delimiter goes out raw, everything after it is escaped
		w.tx_byte   = frame[0];
		w.frame_end = 1'b0;
		words_due.push_back(w);
		for (int i = 1; i < 32; i++) begin
			if (frame[i] == DELIM_BYTE || frame[i] == ESC_BYTE ||
					frame[i] == XON_BYTE || frame[i] == XOFF_BYTE) begin
				w.tx_byte   = ESC_BYTE;
				w.frame_end = 1'b0;
				words_due.push_back(w);
				w.tx_byte = frame[i] ^ ESC_FLIP;
			end else begin
				w.tx_byte = frame[i];
			end
			w.frame_end = (i == 31);
			words_due.push_back(w);
		end
	endtask

	// track the register, predict on input words, compare on output words
	always @(posedge clk) begin
		out_word_t want;
		if (!arst_n) begin
			dest_copy = DEST_RESET;
			words_due.delete();
		end else begin
			if (cfg_wr_en) begin
				dest_copy = cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				queue_frame_words(in_data);
			end
			if (out_valid && !out_stall) begin
				if (words_due.size() == 0) begin
					report_mismatch("word with nothing due", out_data.tx_byte, 8'h00);
				end else begin
					want = words_due.pop_front();
					if (out_data.tx_byte !== want.tx_byte) begin
						report_mismatch("tx_byte", out_data.tx_byte, want.tx_byte);
					end
					if (out_data.frame_end !== want.frame_end) begin
						report_mismatch("frame_end", {7'b0, out_data.frame_end},
							{7'b0, want.frame_end});
					end
				end
			end
		end
		words_due_count = words_due.size();
	end

endmodule

/* tb/radio_tx_frame_builder_escaped_test.sv */
module radio_tx_frame_builder_escaped_test
	import rtfb_pkg::*;
;

	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 70;
	localparam int PHASE_RECORDS = 101;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	in_word_t    in_data     = '0;
	logic        out_stall   = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [63:0] cfg_wr_data = '0;
	logic        in_stall;
	logic        out_valid;
	out_word_t   out_data;

	int fail_count;
	int words_due_count;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int idle_cycles = 0;
	int hold_count  = 0;
	bit hold_toggle = 1'b0;
	bit hold_seen   = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	radio_tx_frame_builder_escaped DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	frame_word_checker frame_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.fail_count      (fail_count),
		.words_due_count (words_due_count)
	);

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen  = hold_toggle;
			hold_count = HOLD_CYCLES;
		end
		if (hold_count > 0) begin
			hold_count--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// drop the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// byte values weighted toward the ones that get escaped
	function automatic logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(99);
		if (roll < 25) begin
			case ($urandom_range(3))
				0: return DELIM_BYTE;
				1: return ESC_BYTE;
				2: return XON_BYTE;
				default: return XOFF_BYTE;
			endcase
		end
		if (roll < 35) return 8'h00;
		if (roll < 45) return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic in_word_t pick_record();
		logic [111:0] bits;
		for (int i = 0; i < 14; i++) begin
			bits[8 * i +: 8] = pick_byte();
		end
		return in_word_t'(bits);
	endfunction

	function automatic logic [63:0] pick_dest();
		logic [63:0] bits;
		for (int i = 0; i < 8; i++) begin
			bits[8 * i +: 8] = pick_byte();
		end
		return bits;
	endfunction

	// offer one record after a random gap, hold it until taken
	task automatic send_record(input in_word_t rec);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= rec;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering and wait for every due word to come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_due_count != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_dest(input logic [63:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		tx_idle_pct = 12;
		rx_idle_pct = 45;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// broadcast address: field extremes and escaped field bytes
		send_record(in_word_t'{16'h0000, 24'h000000, 8'h00, 64'h0});
		send_record(in_word_t'{16'hFFFF, 24'hFFFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF});
		send_record(in_word_t'{16'h7E7D, 24'h11137E, 8'h7D, 64'h7E7D_1113_137D_117E});
		send_record(in_word_t'{16'h1311, 24'h7D7E13, 8'h11, 64'h1311_7E7D_0000_FFFF});

		// last payload byte picked so the checksum is a reserved byte
		send_record(in_word_t'{16'h0000, 24'h000000, 8'h00, 64'h75});
		send_record(in_word_t'{16'h0000, 24'h000000, 8'h00, 64'h76});
		send_record(in_word_t'{16'h0000, 24'h000000, 8'h00, 64'hE2});
		send_record(in_word_t'{16'h0000, 24'h000000, 8'h00, 64'hE0});

		// address extremes
		wait_drained();
		write_dest(64'h0);
		send_record(in_word_t'{16'h0000, 24'h000000, 8'h00, 64'h0});
		send_record(in_word_t'{16'hA55A, 24'h123456, 8'h08, 64'h0102_0304_0506_0708});
		wait_drained();
		write_dest(64'hFFFF_FFFF_FFFF_FFFF);
		send_record(in_word_t'{16'hFFFF, 24'hFFFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF});
		send_record(in_word_t'{16'h8001, 24'h800001, 8'h80, 64'h8000_0000_0000_0001});

		// address made of reserved bytes, then a frame escaped almost everywhere
		wait_drained();
		write_dest(64'h7E7D_1113_1311_7D7E);
		send_record(in_word_t'{16'h0000, 24'h000000, 8'h00, 64'h0});
		send_record(in_word_t'{16'h7E7E, 24'h111111, 8'h13, 64'h7D7D_7D7D_7D7D_7D7D});
		send_record(in_word_t'{16'h1313, 24'h7E7D11, 8'h7E, 64'h1111_1313_7E7E_7D7D});

		// random phases: sender idles lightly, then receiver idles lightly, then neither
		for (int phase = 0; phase < 3; phase++) begin
			wait_drained();
			write_dest(phase == 1 ? {$urandom, $urandom} : pick_dest());
			case (phase)
				0: begin
					tx_idle_pct = 12;
					rx_idle_pct = 45;
				end
				1: begin
					tx_idle_pct = 45;
					rx_idle_pct = 12;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_RECORDS; n++) begin
				// hold the output while records keep coming, or pause the input
				if (phase == 0 && n == 30) hold_toggle = !hold_toggle;
				if (phase == 1 && n == 50) wait_drained();
				send_record(pick_record());
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* radio_tx_frame_builder_escaped.f */
sv/rtfb_pkg.sv
sv/rtfb_ctrl.sv
sv/rtfb_dp.sv
sv/radio_tx_frame_builder_escaped.sv
tb/frame_word_checker.sv
tb/radio_tx_frame_builder_escaped_test.sv
